### src/tilt_to_azimuth_altitude_core_macros.svh
// ------------------------------------------------------------------------------------------
// Assertion macros for the tilt to azimuth and altitude core
// Checks that hold on the clock and reset of the module using them, empty for synthesis.
// ------------------------------------------------------------------------------------------
`ifndef TILT_TO_AZIMUTH_ALTITUDE_CORE_MACROS_SVH
`define TILT_TO_AZIMUTH_ALTITUDE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tta: property failed");
`define TTA_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("tta: forbidden condition seen");
`else
`define TTA_ASSERT(lbl, prop)
`define TTA_NEVER(lbl, expr)
`endif
`endif

### src/tta_pkg.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude package
// Shared widths, CORDIC constants and the item type passed from the front to the back.
// ------------------------------------------------------------------------------------------
package tta_pkg;

   localparam int ROT_W       = 33;
   localparam int VEC_W       = 35;
   localparam int ZW          = 33;
   localparam int MAG_W       = 33;
   localparam int TAB_LEN     = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCOUNT_W    = 3;

   localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;
   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
   localparam logic [17:0] DIV90_RECIP  = 18'd186413;

   localparam logic [29:0] ATAN_BAU [TAB_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
   };

   typedef enum logic [2:0] {
      KIND_CORDIC,
      KIND_ZERO,
      KIND_X_ZERO,
      KIND_Y_ZERO,
      KIND_DIAG
   } kind_type;

   typedef struct packed {
      logic [15:0] ax;
      logic [15:0] ay;
      logic        nx;
      logic        ny;
      logic        ax90;
      logic        ay90;
      kind_type    kind;
   } item_type;

endpackage

### src/tilt_to_azimuth_altitude_core.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude core
// Turns stylus tilt angles in X and Y into pen azimuth and altitude in fixed-point degrees.
// ------------------------------------------------------------------------------------------
// The core takes one item per clock while its input queue is not full and returns one result
// item for each, in order. The path is two unrolled CORDIC rotation pipelines for the tilt
// sines and cosines followed by two unrolled CORDIC vectoring pipelines, one for azimuth and
// one for altitude, each stage one register. A four-entry queue at the input keeps accepting
// items until it is full while a finished result waits on rsp_tready, and the whole back
// pipeline holds while it waits.
module tilt_to_azimuth_altitude_core #(
   parameter int FRAC_BITS     = 8,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // tilt_x [15:0], tilt_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // azimuth [16:0], altitude [31:17]
);
   import tta_pkg::*;

   logic        push;
   logic        full;
   logic        empty;
   logic        pop;
   item_type    front_item;
   item_type    head_item;
   logic [16:0] azimuth;
   logic [14:0] altitude;

   tta_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .tilt_x     (req_tdata[15:0]),
      .tilt_y     (req_tdata[31:16]),
      .full       (full),
      .push       (push),
      .item       (front_item)
   );

   tta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head_item)
   );

   tta_back #(.FRAC_BITS(FRAC_BITS), .STAGES(CORDIC_STAGES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!empty),
      .in_item    (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .azimuth    (azimuth),
      .altitude   (altitude)
   );

   assign rsp_tdata = {altitude, azimuth};

endmodule

### src/tta_front.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude front
// Accepts tilt items, saturates their magnitudes at 90 degrees and classifies the edge cases.
// ------------------------------------------------------------------------------------------
module tta_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        tilt_x,
   input  logic [15:0]        tilt_y,
   input  logic               full,
   output logic               push,
   output tta_pkg::item_type  item
);
   import tta_pkg::*;

   localparam logic [31:0] DEG90 = 32'(90) << FRAC_BITS;

   logic [16:0] mag_x;
   logic [16:0] mag_y;
   logic [15:0] ax;
   logic [15:0] ay;

   always_comb begin
      mag_x = tilt_x[15] ? 17'(-$signed({tilt_x[15], tilt_x})) : {1'b0, tilt_x};
      mag_y = tilt_y[15] ? 17'(-$signed({tilt_y[15], tilt_y})) : {1'b0, tilt_y};
      ax = (32'(mag_x) > DEG90) ? DEG90[15:0] : mag_x[15:0];
      ay = (32'(mag_y) > DEG90) ? DEG90[15:0] : mag_y[15:0];
      item.ax   = ax;
      item.ay   = ay;
      item.nx   = tilt_x[15];
      item.ny   = tilt_y[15];
      item.ax90 = (32'(ax) == DEG90);
      item.ay90 = (32'(ay) == DEG90);
      if (ax == '0 && ay == '0) begin
         item.kind = KIND_ZERO;
      end else if (ax == '0) begin
         item.kind = KIND_X_ZERO;
      end else if (ay == '0) begin
         item.kind = KIND_Y_ZERO;
      end else if (item.ax90 && item.ay90) begin
         item.kind = KIND_DIAG;
      end else begin
         item.kind = KIND_CORDIC;
      end
   end

   assign req_tready = !full;
   assign push       = req_tvalid && !full;

endmodule

### src/tta_queue.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude queue
// Short first-in first-out buffer of classified items between the front and the back.
// ------------------------------------------------------------------------------------------
`include "tilt_to_azimuth_altitude_core_macros.svh"

module tta_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tta_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tta_pkg::item_type head
);
   import tta_pkg::*;

   item_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QCOUNT_W-1:0]  count_ff;
   logic [QCOUNT_W-1:0]  count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `TTA_NEVER(a_count_over, count_ff > QCOUNT_W'(QUEUE_DEPTH))
   `TTA_ASSERT(a_count_up, do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
   `TTA_ASSERT(a_count_down, do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)

endmodule

### src/tta_rot.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude rotation unit
// Unrolled CORDIC rotation giving the sine and cosine of one angle in binary angle units.
// ------------------------------------------------------------------------------------------
module tta_rot #(
   parameter int STAGES = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [tta_pkg::ZW-1:0]      angle,
   output logic signed [tta_pkg::ROT_W-1:0]   sin_out,
   output logic signed [tta_pkg::ROT_W-1:0]   cos_out
);
   import tta_pkg::*;

   logic signed [ROT_W-1:0] x_ff [STAGES];
   logic signed [ROT_W-1:0] y_ff [STAGES];
   logic signed [ZW-1:0]    z_ff [STAGES-1];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [ROT_W-1:0] x_prev;
      logic signed [ROT_W-1:0] y_prev;
      logic signed [ZW-1:0]    z_prev;
      logic signed [ROT_W-1:0] x_in;
      logic signed [ROT_W-1:0] y_in;

      if (i == 0) begin : g_first
         assign x_prev = $signed(ROT_W'(GAIN_INV_Q30));
         assign y_prev = '0;
         assign z_prev = angle;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_comb begin
         if (!z_prev[ZW-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
         end
      end

      if (i < STAGES - 1) begin : g_angle
         logic signed [ZW-1:0] z_in;
         always_comb begin
            z_in = z_prev[ZW-1] ? z_prev + $signed(ZW'(ATAN_BAU[i]))
                                : z_prev - $signed(ZW'(ATAN_BAU[i]));
         end
         always_ff @(posedge clock) begin
            if (en) begin
               z_ff[i] <= z_in;
            end
         end
      end
   end

   assign sin_out = y_ff[STAGES-1];
   assign cos_out = x_ff[STAGES-1];

endmodule

### src/tta_vec.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude vectoring unit
// Unrolled CORDIC vectoring of a non-negative vector, giving its angle in degrees and length.
// ------------------------------------------------------------------------------------------
module tta_vec #(
   parameter int FRAC_BITS = 8,
   parameter int STAGES    = 16
) (
   input  logic                                          clock,
   input  logic                                          en,
   input  logic signed [tta_pkg::VEC_W-1:0]              x_start,
   input  logic signed [tta_pkg::VEC_W-1:0]              y_start,
   output logic [$clog2(32'(360) << FRAC_BITS):0]        ang_out,
   output logic [tta_pkg::MAG_W-1:0]                     mag_out
);
   import tta_pkg::*;

   localparam int ANG_W = $clog2(32'(360) << FRAC_BITS) + 1;
   localparam logic [31:0] DEG90 = 32'(90) << FRAC_BITS;

   typedef enum logic [1:0] {
      VEC_RUN,
      VEC_FLAT,
      VEC_UPRIGHT
   } mode_type;

   mode_type                mode_start;
   mode_type                mode_ff [STAGES];
   logic signed [VEC_W-1:0] x_ff [STAGES];
   logic signed [VEC_W-1:0] y_ff [STAGES-1];
   logic signed [ZW-1:0]    z_ff [STAGES];
   logic [30:0]             z_clip;
   logic [39:0]             deg_full;
   logic [VEC_W-2:0]        x_clip;
   logic [63:0]             mag_full;
   logic [ANG_W-1:0]        ang_in;
   logic [MAG_W-1:0]        mag_in;

   always_comb begin
      if (y_start[VEC_W-1] || y_start == '0) begin
         mode_start = VEC_FLAT;
      end else if (x_start[VEC_W-1] || x_start == '0) begin
         mode_start = VEC_UPRIGHT;
      end else begin
         mode_start = VEC_RUN;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      mode_type                mode_prev;
      logic signed [VEC_W-1:0] x_prev;
      logic signed [VEC_W-1:0] y_prev;
      logic signed [ZW-1:0]    z_prev;
      logic signed [VEC_W-1:0] x_in;
      logic signed [VEC_W-1:0] y_in;
      logic signed [ZW-1:0]    z_in;

      if (i == 0) begin : g_first
         assign mode_prev = mode_start;
         assign x_prev    = (mode_start == VEC_UPRIGHT) ? y_start : x_start;
         assign y_prev    = y_start;
         assign z_prev    = '0;
      end else begin : g_next
         assign mode_prev = mode_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
      end

      always_comb begin
         x_in = x_prev;
         y_in = y_prev;
         z_in = z_prev;
         if (mode_prev == VEC_RUN) begin
            if (!y_prev[VEC_W-1]) begin
               x_in = x_prev + (y_prev >>> i);
               y_in = y_prev - (x_prev >>> i);
               z_in = z_prev + $signed(ZW'(ATAN_BAU[i]));
            end else begin
               x_in = x_prev - (y_prev >>> i);
               y_in = y_prev + (x_prev >>> i);
               z_in = z_prev - $signed(ZW'(ATAN_BAU[i]));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mode_ff[i] <= mode_prev;
            x_ff[i]    <= x_in;
            z_ff[i]    <= z_in;
         end
      end

      if (i < STAGES - 1) begin : g_cross
         always_ff @(posedge clock) begin
            if (en) begin
               y_ff[i] <= y_in;
            end
         end
      end
   end

   always_comb begin
      if (z_ff[STAGES-1][ZW-1]) begin
         z_clip = '0;
      end else if (z_ff[STAGES-1] > $signed(ZW'(ONE_Q30))) begin
         z_clip = ONE_Q30;
      end else begin
         z_clip = z_ff[STAGES-1][30:0];
      end
      deg_full = 40'(z_clip) * 40'd360 + (40'(1) << (31 - FRAC_BITS));
      x_clip   = x_ff[STAGES-1][VEC_W-1] ? '0 : x_ff[STAGES-1][VEC_W-2:0];
      mag_full = 64'(x_clip) * 64'(GAIN_INV_Q30) + (64'(1) << 29);
      case (mode_ff[STAGES-1])
         VEC_RUN: begin
            ang_in = ANG_W'(deg_full >> (32 - FRAC_BITS));
            mag_in = MAG_W'(mag_full >> 30);
         end
         VEC_UPRIGHT: begin
            ang_in = ANG_W'(DEG90);
            mag_in = MAG_W'(x_clip);
         end
         default: begin
            ang_in = '0;
            mag_in = MAG_W'(x_clip);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_out <= ang_in;
         mag_out <= mag_in;
      end
   end

endmodule

### src/tta_back.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude back
// Pipeline from tilt magnitudes through sine and cosine, pen direction and the two angles.
// ------------------------------------------------------------------------------------------
module tta_back #(
   parameter int FRAC_BITS = 8,
   parameter int STAGES    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tta_pkg::item_type in_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [16:0]       azimuth,
   output logic [14:0]       altitude
);
   import tta_pkg::*;

   localparam int ANG_W = $clog2(32'(360) << FRAC_BITS) + 1;
   localparam int LEN   = 3 * STAGES + 6;
   localparam int IT_N  = 3 * STAGES + 5;
   localparam logic signed [ANG_W:0] DEG45  = (ANG_W+1)'(32'(45) << FRAC_BITS);
   localparam logic signed [ANG_W:0] DEG90  = (ANG_W+1)'(32'(90) << FRAC_BITS);
   localparam logic signed [ANG_W:0] DEG180 = (ANG_W+1)'(32'(180) << FRAC_BITS);
   localparam logic signed [ANG_W:0] DEG360 = (ANG_W+1)'(32'(360) << FRAC_BITS);

   typedef logic [29:0] frac_tab_type [90];

   function automatic frac_tab_type build_frac_tab();
      frac_tab_type t;
      for (int l = 0; l < 90; l++) begin
         t[l] = 30'(((64'(l) << (30 - FRAC_BITS)) + 64'd45) / 64'd90);
      end
      return t;
   endfunction

   localparam frac_tab_type BAU_FRAC = build_frac_tab();

   function automatic logic signed [ZW-1:0] to_bau(input logic [33:0] hm,
                                                    input logic [15:0] a);
      logic [9:0]  h0;
      logic [16:0] l0;
      logic [9:0]  h;
      logic [6:0]  l;
      h0 = hm[33:24];
      l0 = 17'(a) - 17'(h0) * 17'd90;
      if (l0 >= 17'd90) begin
         h = h0 + 10'd1;
         l = 7'(l0 - 17'd90);
      end else begin
         h = h0;
         l = l0[6:0];
      end
      return $signed((ZW'(h) << (30 - FRAC_BITS)) + ZW'(BAU_FRAC[l]));
   endfunction

   function automatic logic [30:0] clip31(input logic signed [ROT_W-1:0] v);
      return v[ROT_W-1] ? '0 : v[30:0];
   endfunction

   function automatic logic [31:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b) + (62'(1) << 29);
      return p[61:30];
   endfunction

   logic                    adv;
   logic                    vld_ff [LEN];
   item_type                item_ff [IT_N];
   logic [33:0]             hmx_ff;
   logic [33:0]             hmy_ff;
   logic signed [ZW-1:0]    zx_ff;
   logic signed [ZW-1:0]    zy_ff;
   logic signed [ROT_W-1:0] sx_rot;
   logic signed [ROT_W-1:0] cx_rot;
   logic signed [ROT_W-1:0] sy_rot;
   logic signed [ROT_W-1:0] cy_rot;
   logic [30:0]             sx;
   logic [30:0]             cx;
   logic [30:0]             sy;
   logic [30:0]             cy;
   logic [31:0]             p_ff;
   logic [31:0]             q_ff;
   logic [31:0]             c_ff [STAGES+2];
   logic [ANG_W-1:0]        phi_vec;
   logic [MAG_W-1:0]        mag_vec;
   logic [ANG_W-1:0]        phi_ff [STAGES+1];
   logic [ANG_W-1:0]        alt_vec;
   item_type                fin;
   logic signed [ANG_W:0]   phi;
   logic signed [ANG_W:0]   alt;
   logic signed [ANG_W:0]   az;
   logic [16:0]             az_ff;
   logic [14:0]             alt_ff;

   assign adv        = !vld_ff[LEN-1] || rsp_tready;
   assign pop        = adv && in_valid;
   assign rsp_tvalid = vld_ff[LEN-1];
   assign azimuth    = az_ff;
   assign altitude   = alt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LEN; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < LEN; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= in_item;
         for (int k = 1; k < IT_N; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
         hmx_ff <= 34'(in_item.ax) * 34'(DIV90_RECIP);
         hmy_ff <= 34'(in_item.ay) * 34'(DIV90_RECIP);
         zx_ff  <= to_bau(hmx_ff, item_ff[0].ax);
         zy_ff  <= to_bau(hmy_ff, item_ff[0].ay);
      end
   end

   tta_rot #(.STAGES(STAGES)) u_rot_x (
      .clock   (clock),
      .en      (adv),
      .angle   (zx_ff),
      .sin_out (sx_rot),
      .cos_out (cx_rot)
   );

   tta_rot #(.STAGES(STAGES)) u_rot_y (
      .clock   (clock),
      .en      (adv),
      .angle   (zy_ff),
      .sin_out (sy_rot),
      .cos_out (cy_rot)
   );

   always_comb begin
      sx = item_ff[STAGES+1].ax90 ? ONE_Q30 : clip31(sx_rot);
      cx = item_ff[STAGES+1].ax90 ? '0 : clip31(cx_rot);
      sy = item_ff[STAGES+1].ay90 ? ONE_Q30 : clip31(sy_rot);
      cy = item_ff[STAGES+1].ay90 ? '0 : clip31(cy_rot);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff     <= mul_q30(sx, cy);
         q_ff     <= mul_q30(sy, cx);
         c_ff[0]  <= mul_q30(cx, cy);
         for (int k = 1; k < STAGES + 2; k++) begin
            c_ff[k] <= c_ff[k-1];
         end
         phi_ff[0] <= phi_vec;
         for (int k = 1; k < STAGES + 1; k++) begin
            phi_ff[k] <= phi_ff[k-1];
         end
      end
   end

   tta_vec #(.FRAC_BITS(FRAC_BITS), .STAGES(STAGES)) u_vec_azim (
      .clock   (clock),
      .en      (adv),
      .x_start ($signed(VEC_W'(p_ff))),
      .y_start ($signed(VEC_W'(q_ff))),
      .ang_out (phi_vec),
      .mag_out (mag_vec)
   );

   tta_vec #(.FRAC_BITS(FRAC_BITS), .STAGES(STAGES)) u_vec_alt (
      .clock   (clock),
      .en      (adv),
      .x_start ($signed(VEC_W'(mag_vec))),
      .y_start ($signed(VEC_W'(c_ff[STAGES+1]))),
      .ang_out (alt_vec),
      .mag_out ()
   );

   always_comb begin
      fin = item_ff[IT_N-1];
      case (fin.kind)
         KIND_ZERO: begin
            phi = '0;
            alt = DEG90;
         end
         KIND_X_ZERO: begin
            phi = DEG90;
            alt = DEG90 - $signed((ANG_W+1)'(fin.ay));
         end
         KIND_Y_ZERO: begin
            phi = '0;
            alt = DEG90 - $signed((ANG_W+1)'(fin.ax));
         end
         KIND_DIAG: begin
            phi = DEG45;
            alt = '0;
         end
         default: begin
            phi = $signed({1'b0, phi_ff[STAGES]});
            alt = (fin.ax90 || fin.ay90) ? '0 : $signed({1'b0, alt_vec});
         end
      endcase
      if (!fin.nx && !fin.ny) begin
         az = phi;
      end else if (fin.nx && !fin.ny) begin
         az = DEG180 - phi;
      end else if (fin.nx && fin.ny) begin
         az = DEG180 + phi;
      end else begin
         az = DEG360 - phi;
      end
      if (az >= DEG360) begin
         az = az - DEG360;
      end
      if (az < 0) begin
         az = '0;
      end
      if (alt < 0) begin
         alt = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         az_ff  <= 17'(az);
         alt_ff <= 15'(alt);
      end
   end

endmodule

### verif/tilt_to_azimuth_altitude_core_checker.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude result checker
// Watches both streams, predicts each item's azimuth and altitude with a CORDIC model of
// its own, and compares every result item with the oldest prediction in order.
// ------------------------------------------------------------------------------------------
module tilt_to_azimuth_altitude_core_checker #(
   parameter int FRAC_BITS     = 8,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   import tta_pkg::*;

   localparam longint ONE = longint'(1) << 30;
   localparam longint GAIN = 652032874;

   typedef struct packed {
      logic [14:0] altitude;
      logic [16:0] azimuth;
   } angles_type;

   angles_type angles_q[$];

   function automatic longint deg(longint d);
      return d <<< FRAC_BITS;
   endfunction

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint mulq(longint a, longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic longint to_bau(longint a);
      return ((a << 32) + (longint'(180) << FRAC_BITS)) / (longint'(360) << FRAC_BITS);
   endfunction

   function automatic longint from_bau(longint z);
      longint p;
      if (z < 0) z = 0;
      if (z > ONE) z = ONE;
      p = (z * 360) << FRAC_BITS;
      return (p + (longint'(1) << 31)) >>> 32;
   endfunction

   function automatic void rotate(input longint a, output longint s, output longint c);
      longint x, y, z, nx;
      x = GAIN;
      y = 0;
      if (a >= deg(90)) begin
         s = ONE;
         c = 0;
         return;
      end
      z = to_bau(a);
      for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
         if (z >= 0) begin
            nx = x - asr(y, i);
            y = y + asr(x, i);
            z -= longint'(ATAN_BAU[i]);
         end else begin
            nx = x + asr(y, i);
            y = y - asr(x, i);
            z += longint'(ATAN_BAU[i]);
         end
         x = nx;
      end
      s = (y < 0) ? 0 : y;
      c = (x < 0) ? 0 : x;
   endfunction

   function automatic void vector(input longint x, input longint y, output longint ang,
                                  output longint mag);
      longint z, nx;
      z = 0;
      if (y <= 0) begin
         mag = x;
         ang = 0;
         return;
      end
      if (x <= 0) begin
         mag = y;
         ang = deg(90);
         return;
      end
      for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
         if (y >= 0) begin
            nx = x + asr(y, i);
            y = y - asr(x, i);
            z += longint'(ATAN_BAU[i]);
         end else begin
            nx = x - asr(y, i);
            y = y + asr(x, i);
            z -= longint'(ATAN_BAU[i]);
         end
         x = nx;
      end
      if (x < 0) x = 0;
      mag = mulq(x, GAIN);
      ang = from_bau(z);
   endfunction

   function automatic angles_type predict_angles(logic signed [15:0] tx,
                                                 logic signed [15:0] ty);
      angles_type r;
      longint ax, ay, phi, alt, az, sx, cx, sy, cy, mag, dummy;
      logic nx, ny;
      nx = tx < 0;
      ny = ty < 0;
      ax = nx ? -longint'(tx) : longint'(tx);
      ay = ny ? -longint'(ty) : longint'(ty);
      if (ax > deg(90)) ax = deg(90);
      if (ay > deg(90)) ay = deg(90);
      if (ax == 0 && ay == 0) begin
         phi = 0;
         alt = deg(90);
      end else if (ax == 0) begin
         phi = deg(90);
         alt = deg(90) - ay;
      end else if (ay == 0) begin
         phi = 0;
         alt = deg(90) - ax;
      end else if (ax == deg(90) && ay == deg(90)) begin
         phi = deg(45);
         alt = 0;
      end else begin
         rotate(ax, sx, cx);
         rotate(ay, sy, cy);
         vector(mulq(sx, cy), mulq(sy, cx), phi, mag);
         if (ax == deg(90) || ay == deg(90)) alt = 0;
         else vector(mag, mulq(cx, cy), alt, dummy);
      end
      if (!nx && !ny) az = phi;
      else if (nx && !ny) az = deg(180) - phi;
      else if (nx && ny) az = deg(180) + phi;
      else az = deg(360) - phi;
      if (az >= deg(360)) az -= deg(360);
      if (az < 0) az = 0;
      if (alt < 0) alt = 0;
      r.azimuth = az[16:0];
      r.altitude = alt[14:0];
      return r;
   endfunction

   always @(posedge clock) begin
      angles_type want, got;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            angles_q.push_back(predict_angles(req_tdata[15:0], req_tdata[31:16]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (angles_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = angles_q.pop_front();
               if (got.azimuth != want.azimuth || got.altitude != want.altitude) begin
                  if (fail_count < 10) begin
                     $display("mismatch: azimuth exp %0d got %0d, altitude exp %0d got %0d",
                              want.azimuth, got.azimuth, want.altitude, got.altitude);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= angles_q.size();
      end
   end

endmodule

### verif/tilt_to_azimuth_altitude_core_tb.sv
// ------------------------------------------------------------------------------------------
// Tilt to azimuth and altitude core testbench
// Sends directed corner tilts and then random tilts with random gaps on both streams; the
// checker beside the core predicts and compares every result item.
// ------------------------------------------------------------------------------------------
module tilt_to_azimuth_altitude_core_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   bit          sink_on = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tilt_to_azimuth_altitude_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   tilt_to_azimuth_altitude_core_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_tilt();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'($urandom_range(0, 65535));
      if (r < 15) return $urandom_range(0, 1) ? 16'sd23040 : -16'sd23040;
      if (r < 20) return '0;
      if (r < 30) return 16'($signed($urandom_range(0, 512)) - 256);
      return 16'($signed($urandom_range(0, 46080)) - 23040);
   endfunction

   task automatic send_tilt(logic [15:0] tx, logic [15:0] ty);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ty, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (sink_on) rsp_tready <= ($urandom_range(0, 99) < 70);
   end

   initial begin
      #4000000;
      $display("tilt_to_azimuth_altitude_core_tb: FAIL");
      $finish;
   end

   initial begin
      logic [15:0] corner [10];
      int k;
      corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'sd23040, -16'sd23040, 16'sd23041,
                 16'h7FFF, 16'h8000, 16'sd11520, -16'sd5000};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      sink_on = 1'b1;
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 5; j++) send_tilt(corner[2 * i], corner[(2 * j + 1) % 10]);
      end
      for (int n = 0; n < 1500; n++) send_tilt(random_tilt(), random_tilt());
      req_tvalid <= 1'b0;
      k = 0;
      while (pending_count != 0 && k < 200000) begin
         @(posedge clock);
         k++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tilt_to_azimuth_altitude_core_tb: PASS");
      end else begin
         $display("tilt_to_azimuth_altitude_core_tb: FAIL");
      end
      $finish;
   end

endmodule
